// File: rtl/lis_pkg.sv
// Shared types and constants for the LIS length tracker.
`default_nettype none

package lis_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 11;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     first;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/lis_length_tracker_top.sv
// Top level of the longest strictly increasing subsequence length tracker.
// Each item passes through CHECK and FINISH when it lands on the first or last
// tail (or starts a sequence), and otherwise also through SEARCH, with one tail
// memory read per binary search probe, through the single read port, and the
// compare of one probe overlapped with the read of the next. A new item is
// taken only while the sequencer is idle; a finished result waits in an output
// register, and while it is held the next item cannot leave FINISH.
// The tail memory needs no clearing after reset.
`default_nettype none

module lis_length_tracker_top #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lis_pkg::t_in_item   i_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lis_pkg::t_out_item       o_item
);

    import lis_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    t_state                   r_state, n_state;
    logic signed [DATA_W-1:0] r_key;
    logic                     r_first;
    logic [LW-1:0]            r_len, n_len;
    logic                     r_ovf, n_ovf;
    logic signed [DATA_W-1:0] r_head, n_head;
    logic signed [DATA_W-1:0] r_tail, n_tail;
    logic [AW-1:0]            r_lo, n_lo;
    logic [AW-1:0]            r_hi, n_hi;
    logic [AW-1:0]            r_mid, n_mid;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    logic                     w_wr_en, w_rd_en;
    logic [AW-1:0]            w_wr_addr, w_rd_addr;
    logic [DATA_W-1:0]        w_rd_data;

    logic                     w_restart, w_below, w_above, w_do_search;
    logic [AW-1:0]            w_last;
    logic                     w_less;
    logic [AW-1:0]            w_nlo, w_nhi;
    logic                     w_srch_done;
    logic                     w_out_free;
    logic [LW+LEN_W-1:0]      w_len_ext;

    lis_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_last      = AW'(r_len - LW'(1));
    assign w_restart   = r_first || (r_len == '0);
    assign w_below     = r_key < r_head;
    assign w_above     = r_key > r_tail;
    assign w_do_search = !w_restart && !w_below && !w_above && (w_last != '0);
    assign w_less      = $signed(w_rd_data) < r_key;
    assign w_nlo       = w_less ? AW'(r_mid + AW'(1)) : r_lo;
    assign w_nhi       = w_less ? r_hi : r_mid;
    assign w_srch_done = !(w_nlo < w_nhi);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_len_ext   = (LW + LEN_W)'(r_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK:  n_state = w_do_search ? ST_SEARCH : ST_FINISH;
            ST_SEARCH: if (w_srch_done) n_state = ST_FINISH;
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_head      = r_head;
        n_tail      = r_tail;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_mid;
        case (r_state)
            ST_CHECK: begin
                if (w_restart) begin
                    w_wr_en = 1'b1;
                    n_head  = r_key;
                    n_tail  = r_key;
                    n_len   = LW'(1);
                    n_ovf   = 1'b0;
                end else if (w_below) begin
                    w_wr_en = 1'b1;
                    n_head  = r_key;
                    if (w_last == '0) n_tail = r_key;
                end else if (w_above) begin
                    if (r_len < LW'(MAX_LEN)) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_len[AW-1:0];
                        n_tail    = r_key;
                        n_len     = LW'(r_len + LW'(1));
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (w_last == '0) begin
                    w_wr_en = 1'b1;
                end else begin
                    n_lo      = '0;
                    n_hi      = w_last;
                    n_mid     = w_last >> 1;
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_last >> 1;
                end
            end
            ST_SEARCH: begin
                n_lo = w_nlo;
                n_hi = w_nhi;
                if (w_srch_done) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_nlo;
                    if (w_nlo == w_last) n_tail = r_key;
                    if (w_nlo == '0) n_head = r_key;
                end else begin
                    n_mid     = AW'(w_nlo + ((w_nhi - w_nlo) >> 1));
                    w_rd_en   = 1'b1;
                    w_rd_addr = n_mid;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out.length   = w_len_ext[LEN_W-1:0];
                    n_out.overflow = r_ovf;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_key   <= i_item.value;
            r_first <= i_item.first;
        end
        r_head <= n_head;
        r_tail <= n_tail;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_item      = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("length above table size");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_lo < r_hi && r_mid >= r_lo && r_mid < r_hi))
        else $error("search window empty or probe outside it");

    a_restart_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_first) |=> (r_len == LW'(1) && !r_ovf))
        else $error("sequence start did not reset length");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0 && r_state == ST_IDLE) |-> (r_head <= r_tail))
        else $error("first tail above last tail");

endmodule

`default_nettype wire

// File: rtl/lis_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
